@@ hdl/motion_gated_orientation_detector_core_macros.svh @@
`ifndef MOTION_GATED_ORIENTATION_DETECTOR_CORE_MACROS_SVH
`define MOTION_GATED_ORIENTATION_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MGOD_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define MGOD_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mgod_pkg.sv @@
`default_nettype none

package mgod_pkg;

  // Orientation codes carried in the result.
  localparam logic [2:0] ORIENT_NONE   = 3'd0;
  localparam logic [2:0] ORIENT_LEFT   = 3'd1;
  localparam logic [2:0] ORIENT_RIGHT  = 3'd2;
  localparam logic [2:0] ORIENT_TOP    = 3'd3;
  localparam logic [2:0] ORIENT_BOTTOM = 3'd4;
  localparam logic [2:0] ORIENT_FRONT  = 3'd5;
  localparam logic [2:0] ORIENT_BACK   = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MOTION_TOL = 2'd0;
  localparam logic [1:0] CFG_X_TOL      = 2'd1;
  localparam logic [1:0] CFG_Y_TOL      = 2'd2;
  localparam logic [1:0] CFG_Z_TOL      = 2'd3;

  // Reset values of the tolerances.
  localparam logic [15:0] MOTION_TOL_RESET = 16'd1638;
  localparam logic [15:0] X_TOL_RESET      = 16'd1229;
  localparam logic [15:0] Y_TOL_RESET      = 16'd614;
  localparam logic [15:0] Z_TOL_RESET      = 16'd819;

  // Number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Work handed from the front to the back.
  typedef struct packed {
    logic [31:0] sum_sq;
    logic [2:0]  tilt_class;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/mgod_queue.sv @@
`default_nettype none

module mgod_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire mgod_pkg::entry_t push_data,
  output logic                 full,
  input  wire                  pop,
  output mgod_pkg::entry_t     pop_data,
  output logic                 empty
);

  localparam int PtrW = $clog2(mgod_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(mgod_pkg::QUEUE_DEPTH + 1);

  mgod_pkg::entry_t entries [mgod_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CntW'(mgod_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(mgod_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(mgod_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mgod_front.sv @@
`default_nettype none

module mgod_front #(
  parameter int FRAC_BITS = 12
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire signed [15:0]       accel_x,
  input  wire signed [15:0]       accel_y,
  input  wire signed [15:0]       accel_z,
  input  wire signed [15:0]       tilt_x,
  input  wire signed [15:0]       tilt_y,
  input  wire signed [15:0]       tilt_z,
  input  wire [15:0]              x_tolerance,
  input  wire [15:0]              y_tolerance,
  input  wire [15:0]              z_tolerance,
  output logic                    push,
  output mgod_pkg::entry_t        push_data,
  input  wire                     full
);

  localparam logic signed [17:0] ONE = 18'(1 << FRAC_BITS);

  // True when v lies within tol of target, both ends included.
  function automatic logic near(input logic signed [15:0] v,
                                input logic signed [17:0] target,
                                input logic [15:0] tol);
    logic signed [17:0] d;
    logic signed [17:0] nd;
    logic [16:0]        gap;
    d   = $signed({{2{v[15]}}, v}) - target;
    nd  = -d;
    gap = d[17] ? nd[16:0] : d[16:0];
    return gap <= {1'b0, tol};
  endfunction

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic signed [15:0] nv;
    nv = -v;
    return v[15] ? nv : v;
  endfunction

  logic        busy;
  logic [2:0]  step;
  logic [15:0] operand [3];
  logic [31:0] prod;
  logic [31:0] acc;
  logic [2:0]  tilt_class;
  logic [2:0]  class_next;
  logic        accept;
  logic        pending;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign pending  = busy && (step == 3'd4);
  assign push     = pending;

  assign push_data.sum_sq     = acc;
  assign push_data.tilt_class = tilt_class;

  always_comb begin
    if (near(tilt_x, -ONE, x_tolerance)) begin
      class_next = mgod_pkg::ORIENT_LEFT;
    end else if (near(tilt_x, ONE, x_tolerance)) begin
      class_next = mgod_pkg::ORIENT_RIGHT;
    end else if (near(tilt_y, ONE, y_tolerance)) begin
      class_next = mgod_pkg::ORIENT_TOP;
    end else if (near(tilt_y, -ONE, y_tolerance)) begin
      class_next = mgod_pkg::ORIENT_BOTTOM;
    end else if (near(tilt_z, -ONE, z_tolerance)) begin
      class_next = mgod_pkg::ORIENT_FRONT;
    end else if (near(tilt_z, ONE, z_tolerance)) begin
      class_next = mgod_pkg::ORIENT_BACK;
    end else begin
      class_next = mgod_pkg::ORIENT_NONE;
    end
  end

  // Payload: one square per cycle, added in the cycle after it is formed.
  always_ff @(posedge clk) begin
    if (accept) begin
      operand[0] <= abs16(accel_x);
      operand[1] <= abs16(accel_y);
      operand[2] <= abs16(accel_z);
      tilt_class <= class_next;
      acc        <= '0;
    end else if (busy) begin
      if (step < 3'd3) begin
        prod <= operand[step[1:0]] * operand[step[1:0]];
      end
      if (step != 3'd0 && step < 3'd4) begin
        acc <= acc + prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step < 3'd4) begin
        step <= step + 1'b1;
      end else if (!full) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mgod_back.sv @@
`default_nettype none

module mgod_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  empty,
  input  wire mgod_pkg::entry_t pop_data,
  output logic                 pop,
  input  wire [15:0]           motion_tolerance,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 moved,
  output logic [2:0]           orientation,
  output logic [15:0]          magnitude
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  logic [31:0] radicand;
  logic [16:0] rem;
  logic [15:0] root;
  logic [3:0]  count;
  logic [2:0]  tilt_class;
  logic [15:0] previous_magnitude;

  logic [18:0] rem_shift;
  logic [17:0] trial;
  logic        take;
  logic [18:0] rem_sub;
  logic [16:0] mag_diff;
  logic [16:0] mag_diff_neg;
  logic [15:0] mag_change;
  logic        moved_next;
  logic        load_out;

  // One result bit per cycle: bring down two radicand bits, try 4r+1.
  assign rem_shift = {rem, radicand[31:30]};
  assign trial     = {root, 2'b01};
  assign take      = rem_shift >= {1'b0, trial};
  assign rem_sub   = rem_shift - {1'b0, trial};

  assign mag_diff     = {1'b0, root} - {1'b0, previous_magnitude};
  assign mag_diff_neg = -mag_diff;
  assign mag_change   = mag_diff[16] ? mag_diff_neg[15:0] : mag_diff[15:0];
  assign moved_next   = mag_change > motion_tolerance;

  assign pop      = (state == ST_IDLE) && !empty;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      radicand   <= pop_data.sum_sq;
      tilt_class <= pop_data.tilt_class;
      rem        <= '0;
      root       <= '0;
    end else if (state == ST_ROOT) begin
      rem      <= take ? rem_sub[16:0] : rem_shift[16:0];
      root     <= {root[14:0], take};
      radicand <= {radicand[29:0], 2'b00};
    end
    if (load_out) begin
      moved       <= moved_next;
      orientation <= moved_next ? tilt_class : mgod_pkg::ORIENT_NONE;
      magnitude   <= root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      count              <= '0;
      out_valid          <= 1'b0;
      previous_magnitude <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_ROOT;
            count <= '0;
          end
        end
        ST_ROOT: begin
          count <= count + 1'b1;
          if (count == 4'd15) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            previous_magnitude <= root;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/motion_gated_orientation_detector_core.sv @@
// Motion-gated orientation detector. Each input request carries a three-axis
// acceleration and a three-axis tilt vector in signed fixed point with
// FRAC_BITS fraction bits; each produces exactly one result with the truncated
// square root of the summed squared acceleration, a moved flag (magnitude
// changed from the previous sample by more than motion_tolerance) and, when
// moved, the tilt orientation (0 none, 1 left, 2 right, 3 top, 4 bottom,
// 5 front, 6 back, first inclusive window match wins). The front end takes a
// new request only once it has pushed the previous sum, squaring one axis per
// cycle on a single multiplier, and hands the sum through a two-entry queue
// (stalling while it is full) to the back end, whose bit-serial square root
// produces the result one bit at a time before it is delivered.
// The output register lets the next result be computed while one waits.
// Tolerance registers may be written only while the block is idle.
`default_nettype none

module motion_gated_orientation_detector_core #(
  parameter int FRAC_BITS = 12
) (
  input  wire         clk,
  input  wire         rst,
  // s_tdata, lowest bit up: accel_x, accel_y, accel_z, tilt_x, tilt_y, tilt_z
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [95:0]  s_tdata,
  // m_tdata, lowest bit up: moved, orientation[2:0], magnitude[15:0], 4 zero bits
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [15:0]  cfg_data
);

  logic [15:0] motion_tolerance;
  logic [15:0] x_tolerance;
  logic [15:0] y_tolerance;
  logic [15:0] z_tolerance;

  logic             push;
  mgod_pkg::entry_t push_data;
  logic             full;
  logic             pop;
  mgod_pkg::entry_t pop_data;
  logic             empty;

  logic        moved;
  logic [2:0]  orientation;
  logic [15:0] magnitude;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_tolerance <= mgod_pkg::MOTION_TOL_RESET;
      x_tolerance      <= mgod_pkg::X_TOL_RESET;
      y_tolerance      <= mgod_pkg::Y_TOL_RESET;
      z_tolerance      <= mgod_pkg::Z_TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mgod_pkg::CFG_MOTION_TOL: motion_tolerance <= cfg_data;
        mgod_pkg::CFG_X_TOL:      x_tolerance      <= cfg_data;
        mgod_pkg::CFG_Y_TOL:      y_tolerance      <= cfg_data;
        mgod_pkg::CFG_Z_TOL:      z_tolerance      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mgod_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .accel_x    ($signed(s_tdata[15:0])),
    .accel_y    ($signed(s_tdata[31:16])),
    .accel_z    ($signed(s_tdata[47:32])),
    .tilt_x     ($signed(s_tdata[63:48])),
    .tilt_y     ($signed(s_tdata[79:64])),
    .tilt_z     ($signed(s_tdata[95:80])),
    .x_tolerance(x_tolerance),
    .y_tolerance(y_tolerance),
    .z_tolerance(z_tolerance),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  mgod_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  mgod_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (empty),
    .pop_data        (pop_data),
    .pop             (pop),
    .motion_tolerance(motion_tolerance),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .moved           (moved),
    .orientation     (orientation),
    .magnitude       (magnitude)
  );

  assign m_tdata = {4'b0000, magnitude, orientation, moved};

endmodule

`default_nettype wire

@@ hdl/mgod_checker.sv @@
`default_nettype none

`include "motion_gated_orientation_detector_core_macros.svh"

module mgod_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata
);

  // A waiting result is not withdrawn.
  `MGOD_ASSERT_NEXT(a_result_held, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")

  // Orientation is reported only for a sample that moved.
  `MGOD_ASSERT_SAME(a_orient_gated, clk, rst, m_tvalid && !m_tdata[0], m_tdata[3:1] == 3'd0, "orientation without motion")

  // The root of three 16-bit squares never exceeds 56755.
  `MGOD_ASSERT_SAME(a_mag_range, clk, rst, m_tvalid, m_tdata[19:4] <= 16'd56755, "magnitude out of range")

  // Nothing comes out in the cycle after reset.
  `MGOD_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !m_tvalid, "result after reset")

endmodule

bind motion_gated_orientation_detector_core mgod_checker u_mgod_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
